/* hdl/hsseq_pkg.sv */
// types, constants and the coil pattern table for the half-step stepper sequencer
package hsseq_pkg;

  typedef enum logic [1:0] {
    KIND_MOVE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_STOP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } seq_state_e;

  localparam int unsigned SPT_W    = 16;
  localparam int unsigned DEG_W    = 16;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned STEPS_W  = 23;
  localparam int unsigned PERIOD_W = 26;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [SPT_W-1:0]    SPT_RESET       = 16'd200;
  localparam logic [PROD_W-1:0]   DEG_PER_TURN    = 32'd360;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX      = '1;
  localparam logic [STEPS_W-1:0]  STEPS_MAX       = '1;
  localparam logic [PHASE_W-1:0]  PHASE_CW_START  = 3'd0;
  localparam logic [PHASE_W-1:0]  PHASE_CCW_START = 3'd7;
  localparam logic [COIL_W-1:0]   COILS_OFF       = 4'b0000;

  // register index, taken from paddr bit 2
  localparam logic REG_STEPS_PER_TURN = 1'b0;
  localparam logic REG_INVERT_COILS   = 1'b1;

  function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

/* hdl/half_step_stepper_sequencer_unit.sv */
// Half-step sequencer for a four-coil unipolar stepper: takes move, tick and stop items and
// returns one result per item with the coil drive pattern, busy and speed error flags.
// A tick, a stop, an unknown kind or a zero-speed move gives its result in the cycle after the
// transfer, so ticks can stream one per cycle while the result output is not stalled. A move
// with nonzero speed is worked out by one 16x16 multiplier and one shift-subtract divider that
// yields one quotient bit a cycle, both used twice, first for the step count (degrees times
// steps per turn over 360), then for the step period (60*TICKS_PER_SECOND over rpm times
// steps per turn); input is stalled meanwhile. DVD_W, the dividend width, is 32 or the width of
// 60*TICKS_PER_SECOND if wider. There is no clearing pass after reset.
module half_step_stepper_sequencer_unit #(
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [hsseq_pkg::APB_AW-1:0]            paddr,
  input  logic [hsseq_pkg::APB_DW-1:0]            pwdata,
  output logic [hsseq_pkg::APB_DW-1:0]            prdata,
  output logic                                    pready,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [1:0]                              kind_i,
  input  logic signed [hsseq_pkg::DEG_W-1:0]      move_degrees_i,
  input  logic [hsseq_pkg::RPM_W-1:0]             speed_rpm_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [hsseq_pkg::COIL_W-1:0]            coils_o,
  output logic                                    busy_res_o,
  output logic                                    speed_error_o
);

  localparam logic [63:0] PERIOD_NUM = 64'(TICKS_PER_SECOND) * 64'd60;
  localparam int unsigned NUM_W = $clog2(PERIOD_NUM + 64'd1);
  localparam int unsigned DVD_W = (NUM_W > hsseq_pkg::PROD_W) ? NUM_W : hsseq_pkg::PROD_W;
  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam int unsigned PW    = hsseq_pkg::PROD_W;

  // configuration
  logic [hsseq_pkg::SPT_W-1:0]    spt_q;
  logic                           invert_q;
  // motion state
  logic [hsseq_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic                           cw_q, cw_d;
  logic [hsseq_pkg::STEPS_W-1:0]  steps_left_q, steps_left_d;
  logic [hsseq_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [hsseq_pkg::PERIOD_W-1:0] wait_q, wait_d;
  logic                           moving_q, moving_d;
  logic [hsseq_pkg::COIL_W-1:0]   coil_q, coil_d;
  // sequencer and shared arithmetic
  hsseq_pkg::seq_state_e          state_q, state_d;
  logic                           pass_q, pass_d;
  logic [hsseq_pkg::DEG_W-1:0]    mag_q, mag_d;
  logic [hsseq_pkg::RPM_W-1:0]    rpm_q, rpm_d;
  logic [DVD_W-1:0]               quo_q, quo_d;
  logic [PW-1:0]                  rem_q, rem_d;
  logic [PW-1:0]                  div_q, div_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  // result register
  logic                           out_valid_q, out_valid_d;
  logic [hsseq_pkg::COIL_W-1:0]   out_coils_q, out_coils_d;
  logic                           out_busy_q, out_busy_d;
  logic                           out_err_q, out_err_d;

  logic                           accept;
  logic                           cfg_wr;
  logic                           res_load;
  logic                           res_err;
  logic [hsseq_pkg::DEG_W-1:0]    deg_raw;
  logic                           cw_in;
  logic [hsseq_pkg::DEG_W-1:0]    mag_in;
  logic [hsseq_pkg::DEG_W-1:0]    mul_a;
  logic [PW-1:0]                  prod;
  logic [PW:0]                    rem_sh;
  logic [PW+1:0]                  diff;
  logic                           take;
  logic [PW-1:0]                  rem_nxt;
  logic [hsseq_pkg::STEPS_W-1:0]  steps_val;
  logic [hsseq_pkg::PERIOD_W-1:0] period_val;
  logic [hsseq_pkg::PHASE_W-1:0]  ph_nxt;
  logic [hsseq_pkg::STEPS_W-1:0]  steps_dec;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == hsseq_pkg::REG_INVERT_COILS)
                ? {{(hsseq_pkg::APB_DW-1){1'b0}}, invert_q}
                : {{(hsseq_pkg::APB_DW-hsseq_pkg::SPT_W){1'b0}}, spt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q    <= hsseq_pkg::SPT_RESET;
      invert_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == hsseq_pkg::REG_STEPS_PER_TURN) begin
        spt_q <= pwdata[hsseq_pkg::SPT_W-1:0];
      end else begin
        invert_q <= pwdata[0];
      end
    end
  end

  // handshake
  assign in_stall_o  = (state_q != hsseq_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign coils_o       = out_coils_q;
  assign busy_res_o    = out_busy_q;
  assign speed_error_o = out_err_q;

  // move decode: magnitude of the signed degrees, zero counts as anticlockwise
  assign deg_raw = $unsigned(move_degrees_i);
  assign cw_in   = (deg_raw != '0) && !deg_raw[hsseq_pkg::DEG_W-1];
  assign mag_in  = cw_in ? deg_raw : (~deg_raw + 16'd1);

  // shared multiplier
  assign mul_a = pass_q ? rpm_q : mag_q;
  assign prod  = {{(PW-hsseq_pkg::DEG_W){1'b0}}, mul_a} *
                 {{(PW-hsseq_pkg::SPT_W){1'b0}}, spt_q};

  // shared divider, one restoring step a cycle; a zero divisor gives all ones
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, div_q};
  assign take    = !diff[PW+1];
  assign rem_nxt = take ? diff[PW-1:0] : rem_sh[PW-1:0];

  always_comb begin
    if (|quo_q[DVD_W-1:hsseq_pkg::STEPS_W]) begin
      steps_val = hsseq_pkg::STEPS_MAX;
    end else if (quo_q[hsseq_pkg::STEPS_W-1:0] == '0) begin
      steps_val = 23'd1;
    end else begin
      steps_val = quo_q[hsseq_pkg::STEPS_W-1:0];
    end
    if (|quo_q[DVD_W-1:hsseq_pkg::PERIOD_W]) begin
      period_val = hsseq_pkg::PERIOD_MAX;
    end else if (quo_q[hsseq_pkg::PERIOD_W-1:0] == '0) begin
      period_val = 26'd1;
    end else begin
      period_val = quo_q[hsseq_pkg::PERIOD_W-1:0];
    end
  end

  assign ph_nxt    = cw_q ? (phase_q + 3'd1) : (phase_q - 3'd1);
  assign steps_dec = (steps_left_q != '0) ? (steps_left_q - 23'd1) : '0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hsseq_pkg::ST_IDLE: begin
        if (accept && (kind_i == hsseq_pkg::KIND_MOVE) && (speed_rpm_i != '0)) begin
          state_d = hsseq_pkg::ST_MUL;
        end
      end
      hsseq_pkg::ST_MUL: begin
        state_d = hsseq_pkg::ST_DIV;
      end
      hsseq_pkg::ST_DIV: begin
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          state_d = hsseq_pkg::ST_DONE;
        end
      end
      hsseq_pkg::ST_DONE: begin
        state_d = pass_q ? hsseq_pkg::ST_IDLE : hsseq_pkg::ST_MUL;
      end
      default: begin
        state_d = hsseq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and results
  always_comb begin
    phase_d      = phase_q;
    cw_d         = cw_q;
    steps_left_d = steps_left_q;
    period_d     = period_q;
    wait_d       = wait_q;
    moving_d     = moving_q;
    coil_d       = coil_q;
    pass_d       = pass_q;
    mag_d        = mag_q;
    rpm_d        = rpm_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    div_d        = div_q;
    cnt_d        = cnt_q;
    res_load     = 1'b0;
    res_err      = 1'b0;
    case (state_q)
      hsseq_pkg::ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (kind_i)
            hsseq_pkg::KIND_MOVE: begin
              if (speed_rpm_i == '0) begin
                res_err = 1'b1;
              end else begin
                res_load = 1'b0;
                cw_d     = cw_in;
                phase_d  = cw_in ? hsseq_pkg::PHASE_CW_START : hsseq_pkg::PHASE_CCW_START;
                mag_d    = mag_in;
                rpm_d    = speed_rpm_i;
                pass_d   = 1'b0;
              end
            end
            hsseq_pkg::KIND_TICK: begin
              if (moving_q) begin
                if (wait_q > 26'd1) begin
                  wait_d = wait_q - 26'd1;
                end else begin
                  phase_d      = ph_nxt;
                  steps_left_d = steps_dec;
                  if (steps_dec != '0) begin
                    coil_d = hsseq_pkg::half_step_pattern(ph_nxt);
                    wait_d = period_q;
                  end else begin
                    wait_d   = '0;
                    moving_d = 1'b0;
                  end
                end
              end
            end
            hsseq_pkg::KIND_STOP: begin
              coil_d       = hsseq_pkg::COILS_OFF;
              moving_d     = 1'b0;
              steps_left_d = '0;
              wait_d       = '0;
            end
            default: begin
              res_err = 1'b0;
            end
          endcase
        end
      end
      hsseq_pkg::ST_MUL: begin
        rem_d = '0;
        cnt_d = '0;
        if (pass_q) begin
          quo_d = DVD_W'(PERIOD_NUM);
          div_d = prod;
        end else begin
          quo_d = DVD_W'(prod);
          div_d = hsseq_pkg::DEG_PER_TURN;
        end
      end
      hsseq_pkg::ST_DIV: begin
        rem_d = rem_nxt;
        quo_d = {quo_q[DVD_W-2:0], take};
        cnt_d = cnt_q + CNT_W'(1);
      end
      hsseq_pkg::ST_DONE: begin
        if (!pass_q) begin
          steps_left_d = steps_val;
          pass_d       = 1'b1;
        end else begin
          period_d = period_val;
          wait_d   = period_val;
          moving_d = 1'b1;
          coil_d   = hsseq_pkg::half_step_pattern(phase_q);
          res_load = 1'b1;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase

    out_valid_d = res_load || (out_valid_q && out_stall_i);
    out_coils_d = out_coils_q;
    out_busy_d  = out_busy_q;
    out_err_d   = out_err_q;
    if (res_load) begin
      out_coils_d = coil_d ^ {hsseq_pkg::COIL_W{invert_q}};
      out_busy_d  = moving_d;
      out_err_d   = res_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hsseq_pkg::ST_IDLE;
      pass_q       <= 1'b0;
      phase_q      <= hsseq_pkg::PHASE_CW_START;
      cw_q         <= 1'b1;
      steps_left_q <= '0;
      period_q     <= '0;
      wait_q       <= '0;
      moving_q     <= 1'b0;
      coil_q       <= hsseq_pkg::COILS_OFF;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pass_q       <= pass_d;
      phase_q      <= phase_d;
      cw_q         <= cw_d;
      steps_left_q <= steps_left_d;
      period_q     <= period_d;
      wait_q       <= wait_d;
      moving_q     <= moving_d;
      coil_q       <= coil_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    rpm_q       <= rpm_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    cnt_q       <= cnt_d;
    out_coils_q <= out_coils_d;
    out_busy_q  <= out_busy_d;
    out_err_q   <= out_err_d;
  end

  // a running move always has steps and waiting left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (steps_left_q != '0) && (wait_q != '0) && (period_q != '0))
    else $error("moving with no steps or wait left");

  // the result register stays empty while a move is being worked out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != hsseq_pkg::ST_IDLE) |-> !out_valid_q)
    else $error("result pending during move calculation");

  // finishing the period pass always delivers the move's result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hsseq_pkg::ST_DONE) && pass_q |=> out_valid_q && out_busy_q && !out_err_q)
    else $error("move result missing after calculation");

  // items are only taken by an idle sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == hsseq_pkg::ST_IDLE))
    else $error("transfer taken while sequencer busy");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the half-step stepper sequencer unit
`timescale 1ns / 100ps

// predicts every coil result and checks it against what the block returns
class coil_scoreboard #(int unsigned TICK_RATE = 1000000);

  typedef struct packed {
    logic [hsseq_pkg::COIL_W-1:0] coils;
    logic                         busy;
    logic                         err;
  } drive_t;

  logic [hsseq_pkg::SPT_W-1:0]    turn_steps;
  logic                           inv;
  logic [hsseq_pkg::PHASE_W-1:0]  ph;
  logic                           cw;
  logic [hsseq_pkg::STEPS_W-1:0]  steps_left;
  logic [hsseq_pkg::PERIOD_W-1:0] period;
  logic [hsseq_pkg::PERIOD_W-1:0] wait_left;
  logic                           moving;
  logic [hsseq_pkg::COIL_W-1:0]   drive;

  drive_t      pending_drives[$];
  int unsigned mismatches;

  function new();
    turn_steps = hsseq_pkg::SPT_RESET;
    inv        = 1'b0;
    ph         = '0;
    cw         = 1'b1;
    steps_left = '0;
    period     = '0;
    wait_left  = '0;
    moving     = 1'b0;
    drive      = hsseq_pkg::COILS_OFF;
    mismatches = 0;
  endfunction

  function logic [hsseq_pkg::COIL_W-1:0] ring(logic [hsseq_pkg::PHASE_W-1:0] p);
    logic [hsseq_pkg::COIL_W-1:0] bits;
    case (p)
      3'd0:    bits = 4'b0001;
      3'd1:    bits = 4'b0011;
      3'd2:    bits = 4'b0010;
      3'd3:    bits = 4'b0110;
      3'd4:    bits = 4'b0100;
      3'd5:    bits = 4'b1100;
      3'd6:    bits = 4'b1000;
      default: bits = 4'b1001;
    endcase
    return bits;
  endfunction

  function void set_reg(logic sel, logic [hsseq_pkg::APB_DW-1:0] val);
    if (sel == hsseq_pkg::REG_STEPS_PER_TURN) turn_steps = val[hsseq_pkg::SPT_W-1:0];
    else inv = val[0];
  endfunction

  function void launch(logic [hsseq_pkg::DEG_W-1:0] deg, logic [hsseq_pkg::RPM_W-1:0] rpm);
    logic [16:0] mag;
    logic [63:0] steps;
    logic [63:0] den;
    logic [63:0] per;
    // zero degrees falls on the counter-clockwise side
    if (deg != '0 && !deg[hsseq_pkg::DEG_W-1]) begin
      cw  = 1'b1;
      ph  = hsseq_pkg::PHASE_CW_START;
      mag = {1'b0, deg};
    end else begin
      cw  = 1'b0;
      ph  = hsseq_pkg::PHASE_CCW_START;
      mag = (deg == '0) ? 17'd0 : 17'h10000 - {1'b0, deg};
    end
    steps = 64'(mag) * 64'(turn_steps) / 64'd360;
    if (steps == 0) steps = 64'd1;
    if (steps > 64'(hsseq_pkg::STEPS_MAX)) steps = 64'(hsseq_pkg::STEPS_MAX);
    den = 64'(rpm) * 64'(turn_steps);
    per = (den == 0) ? 64'(hsseq_pkg::PERIOD_MAX) : (64'd60 * TICK_RATE) / den;
    if (per > 64'(hsseq_pkg::PERIOD_MAX)) per = 64'(hsseq_pkg::PERIOD_MAX);
    if (per == 0) per = 64'd1;
    steps_left = steps[hsseq_pkg::STEPS_W-1:0];
    period     = per[hsseq_pkg::PERIOD_W-1:0];
    wait_left  = per[hsseq_pkg::PERIOD_W-1:0];
    moving     = 1'b1;
    drive      = ring(ph);
  endfunction

  function void advance();
    if (!moving) return;
    if (wait_left > 1) begin
      wait_left = wait_left - 1'b1;
      return;
    end
    ph = cw ? ph + 1'b1 : ph - 1'b1;
    if (steps_left != 0) steps_left = steps_left - 1'b1;
    if (steps_left != 0) begin
      drive     = ring(ph);
      wait_left = period;
    end else begin
      // last pattern stays on the coils
      wait_left = '0;
      moving    = 1'b0;
    end
  endfunction

  function void note_command(logic [1:0] k, logic [hsseq_pkg::DEG_W-1:0] deg,
                             logic [hsseq_pkg::RPM_W-1:0] rpm);
    drive_t want;
    want.err = 1'b0;
    case (k)
      hsseq_pkg::KIND_MOVE: begin
        if (rpm == '0) want.err = 1'b1;
        else launch(deg, rpm);
      end
      hsseq_pkg::KIND_TICK: advance();
      hsseq_pkg::KIND_STOP: begin
        drive      = hsseq_pkg::COILS_OFF;
        moving     = 1'b0;
        steps_left = '0;
        wait_left  = '0;
      end
      default: ;
    endcase
    want.coils = drive ^ {hsseq_pkg::COIL_W{inv}};
    want.busy  = moving;
    pending_drives.push_back(want);
  endfunction

  task flag(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_drive(logic [hsseq_pkg::COIL_W-1:0] coils, logic busy, logic err);
    drive_t want;
    if (pending_drives.size() == 0) begin
      flag($sformatf("result with nothing pending: coils %b busy %b err %b", coils, busy, err));
      return;
    end
    want = pending_drives.pop_front();
    if (coils !== want.coils) flag($sformatf("coils %b, predicted %b", coils, want.coils));
    if (busy !== want.busy) flag($sformatf("busy %b, predicted %b", busy, want.busy));
    if (err !== want.err) flag($sformatf("speed error %b, predicted %b", err, want.err));
  endtask

endclass

module tb_top;

  localparam int unsigned TICK_RATE       = 1000000;
  localparam logic [1:0]  KIND_UNUSED     = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 215;
  localparam int unsigned MOVE_LATENCY    = 80;
  localparam int unsigned DEG_W           = hsseq_pkg::DEG_W;
  localparam int unsigned RPM_W           = hsseq_pkg::RPM_W;
  localparam int unsigned SPT_W           = hsseq_pkg::SPT_W;
  localparam int unsigned APB_DW          = hsseq_pkg::APB_DW;

  logic                           clk_i;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [hsseq_pkg::APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]              pwdata;
  logic [APB_DW-1:0]              prdata;
  logic                           pready;
  logic                           cmd_valid;
  logic                           cmd_stall;
  logic [1:0]                     cmd_kind;
  logic signed [DEG_W-1:0]        cmd_deg;
  logic [RPM_W-1:0]               cmd_rpm;
  logic                           res_valid;
  logic                           res_stall;
  logic [hsseq_pkg::COIL_W-1:0]   res_coils;
  logic                           res_busy;
  logic                           res_err;

  coil_scoreboard #(TICK_RATE) sb;

  bit          quiet;
  bit          hold_req;
  int unsigned items_sent;
  int unsigned gap_seg;
  bit          gap_calm;

  half_step_stepper_sequencer_unit #(
    .TICKS_PER_SECOND(TICK_RATE)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (cmd_valid),
    .in_stall_o    (cmd_stall),
    .kind_i        (cmd_kind),
    .move_degrees_i(cmd_deg),
    .speed_rpm_i   (cmd_rpm),
    .out_valid_o   (res_valid),
    .out_stall_i   (res_stall),
    .coils_o       (res_coils),
    .busy_res_o    (res_busy),
    .speed_error_o (res_err)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_n && res_valid && !res_stall) sb.check_drive(res_coils, res_busy, res_err);
  end

  // receiver stall: random bursts, calm stretches and one long hold-off
  initial begin : stall_gen
    int unsigned burst;
    int unsigned seg;
    int unsigned hold;
    bit          calm;
    burst = 0;
    seg   = 0;
    hold  = 0;
    calm  = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = 250;
      end
      if (hold != 0) begin
        res_stall <= 1'b1;
        hold--;
      end else if (quiet) begin
        res_stall <= 1'b0;
      end else begin
        if (seg == 0) begin
          seg  = $urandom_range(20, 200);
          calm = ($urandom_range(0, 2) == 0);
        end
        seg--;
        if (burst == 0 && !calm && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 13);
        if (burst != 0) begin
          res_stall <= 1'b1;
          burst--;
        end else begin
          res_stall <= 1'b0;
        end
      end
    end
  end

  task send_item(logic [1:0] k, logic [DEG_W-1:0] deg, logic [RPM_W-1:0] rpm);
    if (!quiet) begin
      if (gap_seg == 0) begin
        gap_seg  = $urandom_range(20, 200);
        gap_calm = ($urandom_range(0, 2) == 0);
      end
      gap_seg--;
      if (!gap_calm && $urandom_range(0, 4) == 0) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
    cmd_kind  <= k;
    cmd_deg   <= deg;
    cmd_rpm   <= rpm;
    cmd_valid <= 1'b1;
    @(posedge clk_i);
    while (cmd_stall) @(posedge clk_i);
    sb.note_command(k, deg, rpm);
    items_sent++;
  endtask

  // ticks carry random junk in the unused fields
  task send_ticks(int unsigned n);
    repeat (n) send_item(hsseq_pkg::KIND_TICK, DEG_W'($urandom), RPM_W'($urandom));
  endtask

  task follow_move(int unsigned cap);
    int unsigned cnt;
    cnt = 0;
    while (sb.moving && cnt < cap) begin
      send_item(hsseq_pkg::KIND_TICK, DEG_W'($urandom), RPM_W'($urandom));
      cnt++;
    end
  endtask

  task drain(int unsigned settle);
    cmd_valid <= 1'b0;
    while (sb.pending_drives.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // write, then read back in the following transfer
  task write_reg(logic sel, logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] mask;
    mask = (sel == hsseq_pkg::REG_STEPS_PER_TURN) ? APB_DW'({SPT_W{1'b1}}) : APB_DW'(1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(sel, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & mask) !== (val & mask))
      sb.flag($sformatf("register %b reads %h, written %h", sel, prdata & mask, val & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task set_config(logic [SPT_W-1:0] spt, logic inv);
    drain(4);
    write_reg(hsseq_pkg::REG_STEPS_PER_TURN, APB_DW'({$urandom_range(0, 65535), spt}));
    write_reg(hsseq_pkg::REG_INVERT_COILS, APB_DW'({$urandom, 1'b0}) | APB_DW'(inv));
  endtask

  function logic [DEG_W-1:0] pick_deg();
    logic [DEG_W-1:0] mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        mag = DEG_W'($urandom_range(0, 30));
        return $urandom_range(0, 1) ? -mag : mag;
      end
      6: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return DEG_W'($urandom);
    endcase
  endfunction

  function logic [RPM_W-1:0] pick_rpm();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return RPM_W'($urandom_range(20000, 65535));
      6:       return RPM_W'($urandom);
      7:       return 16'hFFFF;
      8:       return RPM_W'($urandom_range(1, 20));
      default: return '0;
    endcase
  endfunction

  task run_random(int unsigned n);
    int unsigned target;
    int unsigned pick;
    target = items_sent + n;
    // earlier moves may still run on after a register change
    send_ticks(3);
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_item(hsseq_pkg::KIND_MOVE, pick_deg(), pick_rpm());
        follow_move($urandom_range(5, 150));
        if ($urandom_range(0, 3) == 0)
          send_item(hsseq_pkg::KIND_STOP, DEG_W'($urandom), RPM_W'($urandom));
      end else if (pick < 68) begin
        send_item(hsseq_pkg::KIND_MOVE, DEG_W'($urandom), '0);
      end else if (pick < 76) begin
        send_item(hsseq_pkg::KIND_STOP, DEG_W'($urandom), RPM_W'($urandom));
      end else if (pick < 82) begin
        send_item(KIND_UNUSED, DEG_W'($urandom), RPM_W'($urandom));
      end else begin
        send_ticks($urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    sb         = new();
    quiet      = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    gap_seg    = 0;
    gap_calm   = 1'b0;
    rst_n     <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    cmd_valid <= 1'b0;
    cmd_kind  <= hsseq_pkg::KIND_TICK;
    cmd_deg   <= '0;
    cmd_rpm   <= '0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset register values; idle ticks, stop, unknown kind, zero speed
    send_item(hsseq_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);
    send_item(hsseq_pkg::KIND_STOP, '0, '0);
    send_item(KIND_UNUSED, 16'h8000, 16'h0001);
    send_item(hsseq_pkg::KIND_MOVE, 16'd90, '0);
    // zero degrees goes one step the other way
    send_item(hsseq_pkg::KIND_MOVE, '0, 16'hFFFF);
    send_ticks(4);
    send_item(hsseq_pkg::KIND_MOVE, 16'h7FFF, 16'hFFFF);
    send_ticks(2);
    // a new move replaces the running one
    send_item(hsseq_pkg::KIND_MOVE, 16'h8000, 16'hFFFF);
    send_ticks(2);
    send_item(hsseq_pkg::KIND_STOP, '0, '0);
    send_ticks(1);
    send_item(hsseq_pkg::KIND_MOVE, 16'd1, 16'hFFFF);
    send_ticks(4);
    send_item(hsseq_pkg::KIND_MOVE, 16'hFFFF, 16'd1);
    send_ticks(2);
    send_item(hsseq_pkg::KIND_STOP, '0, '0);
    run_random(ITEMS_PER_PHASE);

    // period rounds to zero; the receiver holds off while ticks keep coming
    set_config(16'hFFFF, 1'b1);
    send_item(hsseq_pkg::KIND_MOVE, 16'd360, 16'hFFFF);
    hold_req = 1'b1;
    send_ticks(60);
    send_item(hsseq_pkg::KIND_STOP, '0, '0);
    run_random(ITEMS_PER_PHASE);

    set_config(16'd1, 1'b0);
    run_random(ITEMS_PER_PHASE);

    // zero steps per turn: one step, saturated period
    set_config(16'd0, 1'b1);
    send_item(hsseq_pkg::KIND_MOVE, 16'd100, 16'd500);
    send_ticks(3);
    run_random(ITEMS_PER_PHASE);

    set_config(16'd8, 1'b0);
    run_random(ITEMS_PER_PHASE);

    set_config(SPT_W'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)));
    run_random(ITEMS_PER_PHASE);

    set_config(SPT_W'($urandom_range(2, 400)), 1'b1);
    run_random(ITEMS_PER_PHASE);

    set_config(hsseq_pkg::SPT_RESET, 1'b0);
    quiet = 1'b1;
    run_random(ITEMS_PER_PHASE);

    drain(MOVE_LATENCY);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/hsseq_pkg.sv
hdl/half_step_stepper_sequencer_unit.sv
tb/tb_top.sv
